// ===== design/gap_buffer_cursor_engine_top_assert.svh =====
// assertion macros for the gap buffer cursor engine
`ifndef GAP_BUFFER_CURSOR_ENGINE_TOP_ASSERT_SVH
`define GAP_BUFFER_CURSOR_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTH
`define GBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbc check failed now");
`define GBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbc check failed next cycle");
`else
`define GBC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define GBC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/gbc_pkg.sv =====
// shared types, constants and helpers of the gap buffer cursor engine
package gbc_pkg;

  localparam int BUF_SIZE_DEF = 4096;

  localparam int OPC_W  = 3;
  localparam int BYTE_W = 8;
  localparam int POS_W  = 12;
  localparam int ROW_W  = 13;
  localparam int COL_W  = 17;
  localparam int TAB_W  = 5;
  localparam int STAT_W = 2;

  localparam logic [TAB_W-1:0]  TAB_RST = 5'd4;
  localparam logic [BYTE_W-1:0] CH_NL   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NUL  = 8'h00;

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT   = 3'd0,
    OP_DELETE   = 3'd1,
    OP_LEFT     = 3'd2,
    OP_RIGHT    = 3'd3,
    OP_SET_MARK = 3'd4,
    OP_CLEAR    = 3'd5,
    OP_CLR_MOD  = 3'd6
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_AT_START = 2'd1,
    ST_AT_END   = 2'd2,
    ST_FULL     = 2'd3
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [BYTE_W-1:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  cursor_pos;
    logic [BYTE_W-1:0] byte_at_cursor;
    logic [ROW_W-1:0]  row_number;
    logic [COL_W-1:0]  column_number;
    logic              mark_valid;
    logic [POS_W-1:0]  mark_index;
    logic              modified;
  } rsp_t;

  // column advance of one byte
  function automatic logic [COL_W-1:0] col_adv(input logic [BYTE_W-1:0] ch,
                                               input logic [TAB_W-1:0] tw);
    logic [COL_W-1:0] adv;
    adv = (ch == CH_TAB) ? COL_W'(tw) : COL_W'(1);
    return adv;
  endfunction

endpackage

// ===== design/gap_buffer_cursor_engine_top.sv =====
// gap buffer cursor engine: top level with command sequencer and text store
// usage
//   in_valid/in_stall/in_data carry one command beat (opcode, data byte).
//   out_valid/out_stall/out_data carry one result beat per command.
//   cfg_valid/cfg_ready/cfg_data write tab_width; cfg_ready is always high.
// timing
//   a command is taken only while the sequencer is idle. the store read is
//   issued when the command is accepted, and the result register loads
//   from the executing state unless it still holds an untaken result, so
//   the next command is taken only after this result has been loaded.
//   a left move across a newline rescans the previous line through the
//   same read port, one byte per cycle, reading bytes back until it reaches
//   the previous newline (read too) or the start of the buffer.
// reset
//   rst_n (synchronous) empties the buffer, sets row and column to 1,
//   clears mark and modified flag and sets tab_width to 4. no clearing
//   pass over the store is needed: only written bytes are ever read.
// stall
//   a finished result waits in the output register; the next result waits
//   in the sequencer, which stays busy and holds in_stall high until taken.
module gap_buffer_cursor_engine_top #(
  parameter int BUF_SIZE = gbc_pkg::BUF_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  gbc_pkg::cmd_t              in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output gbc_pkg::rsp_t              out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [gbc_pkg::TAB_W-1:0]  cfg_data
);

  localparam int AW = $clog2(BUF_SIZE);
  localparam logic [AW-1:0] LAST_IDX = AW'(BUF_SIZE - 1);

  gbc_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]                 gs_r, gs_nxt;
  logic [AW-1:0]                 ge_r, ge_nxt;
  logic [gbc_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic [gbc_pkg::COL_W-1:0]     col_r, col_nxt;
  logic                          mark_set_r, mark_set_nxt;
  logic [AW-1:0]                 mark_pos_r, mark_pos_nxt;
  logic                          dirty_r, dirty_nxt;
  logic [gbc_pkg::BYTE_W-1:0]    cur_byte_r, cur_byte_nxt;
  logic [gbc_pkg::TAB_W-1:0]     tab_w_r, tab_w_nxt;
  logic [gbc_pkg::STAT_W-1:0]    status_r, status_nxt;
  logic [AW-1:0]                 scan_idx_r, scan_idx_nxt;
  logic [gbc_pkg::OPC_W-1:0]     cmd_op_r, cmd_op_nxt;
  logic [gbc_pkg::BYTE_W-1:0]    cmd_byte_r, cmd_byte_nxt;
  logic                          out_valid_r, out_valid_nxt;
  gbc_pkg::rsp_t                 out_data_r, out_data_nxt;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [gbc_pkg::BYTE_W-1:0]    ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [gbc_pkg::BYTE_W-1:0]    ram_rdata;

  logic [AW-1:0]                 gs_inc, gs_dec, gs_dec2, ge_inc, ge_dec, scan_idx_dec;
  logic                          can_emit;
  logic                          finish;
  logic                          out_load;

  assign gs_inc       = gs_r + AW'(1);
  assign gs_dec       = gs_r - AW'(1);
  assign gs_dec2      = gs_dec - AW'(1);
  assign ge_inc       = ge_r + AW'(1);
  assign ge_dec       = ge_r - AW'(1);
  assign scan_idx_dec = scan_idx_r - AW'(1);
  assign can_emit     = !out_valid_r || !out_stall;

  gbc_ram #(
    .WIDTH (gbc_pkg::BYTE_W),
    .DEPTH (BUF_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    gs_nxt        = gs_r;
    ge_nxt        = ge_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    mark_set_nxt  = mark_set_r;
    mark_pos_nxt  = mark_pos_r;
    dirty_nxt     = dirty_r;
    cur_byte_nxt  = cur_byte_r;
    status_nxt    = status_r;
    scan_idx_nxt  = scan_idx_r;
    cmd_op_nxt    = cmd_op_r;
    cmd_byte_nxt  = cmd_byte_r;
    ram_we        = 1'b0;
    ram_waddr     = gs_r;
    ram_wdata     = cmd_byte_r;
    ram_re        = 1'b0;
    ram_raddr     = gs_r;
    finish        = 1'b0;
    out_load      = 1'b0;

    case (state_r)
      gbc_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_op_nxt   = in_data.opcode;
          cmd_byte_nxt = in_data.data_byte;
          status_nxt   = gbc_pkg::ST_OK;
          ram_re       = 1'b1;
          if (in_data.opcode inside {gbc_pkg::OP_DELETE, gbc_pkg::OP_RIGHT}) begin
            ram_raddr = ge_inc;
          end else if (in_data.opcode == gbc_pkg::OP_LEFT) begin
            ram_raddr = gs_dec;
          end
          state_nxt = gbc_pkg::S_EXEC;
        end
      end
      gbc_pkg::S_EXEC: begin
        finish = 1'b1;
        case (cmd_op_r)
          gbc_pkg::OP_INSERT: begin
            if (gs_r >= ge_r) begin
              status_nxt = gbc_pkg::ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = gs_r;
              ram_wdata = cmd_byte_r;
              gs_nxt    = gs_inc;
              if (cmd_byte_r == gbc_pkg::CH_NL) begin
                row_nxt = row_r + gbc_pkg::ROW_W'(1);
                col_nxt = gbc_pkg::COL_W'(1);
              end else begin
                col_nxt = col_r + gbc_pkg::col_adv(cmd_byte_r, tab_w_r);
              end
              mark_set_nxt = 1'b0;
              dirty_nxt    = 1'b1;
            end
          end
          gbc_pkg::OP_DELETE: begin
            if (ge_r >= LAST_IDX) begin
              status_nxt = gbc_pkg::ST_AT_END;
            end else begin
              ge_nxt       = ge_inc;
              cur_byte_nxt = (ge_inc == LAST_IDX) ? gbc_pkg::CH_NUL : ram_rdata;
              mark_set_nxt = 1'b0;
              dirty_nxt    = 1'b1;
            end
          end
          gbc_pkg::OP_LEFT: begin
            if (gs_r == '0) begin
              status_nxt = gbc_pkg::ST_AT_START;
            end else begin
              gs_nxt       = gs_dec;
              ge_nxt       = ge_dec;
              ram_we       = 1'b1;
              ram_waddr    = ge_dec;
              ram_wdata    = ram_rdata;
              cur_byte_nxt = ram_rdata;
              if (mark_set_r && (mark_pos_r == gs_dec)) begin
                mark_pos_nxt = ge_dec;
              end
              if (ram_rdata == gbc_pkg::CH_NL) begin
                row_nxt = row_r - gbc_pkg::ROW_W'(1);
                col_nxt = gbc_pkg::COL_W'(1);
                if (gs_dec != '0) begin
                  finish       = 1'b0;
                  ram_re       = 1'b1;
                  ram_raddr    = gs_dec2;
                  scan_idx_nxt = gs_dec2;
                  state_nxt    = gbc_pkg::S_SCAN;
                end
              end else begin
                col_nxt = col_r - gbc_pkg::col_adv(ram_rdata, tab_w_r);
              end
            end
          end
          gbc_pkg::OP_RIGHT: begin
            if (ge_r >= LAST_IDX) begin
              status_nxt = gbc_pkg::ST_AT_END;
            end else begin
              if (cur_byte_r == gbc_pkg::CH_NL) begin
                row_nxt = row_r + gbc_pkg::ROW_W'(1);
                col_nxt = gbc_pkg::COL_W'(1);
              end else begin
                col_nxt = col_r + gbc_pkg::col_adv(cur_byte_r, tab_w_r);
              end
              ram_we    = 1'b1;
              ram_waddr = gs_r;
              ram_wdata = cur_byte_r;
              if (mark_set_r && (mark_pos_r == ge_r)) begin
                mark_pos_nxt = gs_r;
              end
              gs_nxt       = gs_inc;
              ge_nxt       = ge_inc;
              cur_byte_nxt = (ge_inc == LAST_IDX) ? gbc_pkg::CH_NUL : ram_rdata;
            end
          end
          gbc_pkg::OP_SET_MARK: begin
            mark_set_nxt = 1'b1;
            mark_pos_nxt = ge_r;
          end
          gbc_pkg::OP_CLEAR: begin
            gs_nxt       = '0;
            ge_nxt       = LAST_IDX;
            row_nxt      = gbc_pkg::ROW_W'(1);
            col_nxt      = gbc_pkg::COL_W'(1);
            mark_set_nxt = 1'b0;
            mark_pos_nxt = '0;
            dirty_nxt    = 1'b1;
            cur_byte_nxt = gbc_pkg::CH_NUL;
          end
          gbc_pkg::OP_CLR_MOD: begin
            dirty_nxt = 1'b0;
          end
          default: begin
          end
        endcase
      end
      gbc_pkg::S_SCAN: begin
        if (ram_rdata == gbc_pkg::CH_NL) begin
          finish = 1'b1;
        end else begin
          col_nxt = col_r + gbc_pkg::col_adv(ram_rdata, tab_w_r);
          if (scan_idx_r == '0) begin
            finish = 1'b1;
          end else begin
            ram_re       = 1'b1;
            ram_raddr    = scan_idx_dec;
            scan_idx_nxt = scan_idx_dec;
          end
        end
      end
      gbc_pkg::S_DONE: begin
        if (can_emit) begin
          out_load  = 1'b1;
          state_nxt = gbc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gbc_pkg::S_IDLE;
      end
    endcase

    if (finish) begin
      if (can_emit) begin
        out_load  = 1'b1;
        state_nxt = gbc_pkg::S_IDLE;
      end else begin
        state_nxt = gbc_pkg::S_DONE;
      end
    end

    out_data_nxt.status         = status_nxt;
    out_data_nxt.cursor_pos     = gbc_pkg::POS_W'(gs_nxt);
    out_data_nxt.byte_at_cursor = cur_byte_nxt;
    out_data_nxt.row_number     = row_nxt;
    out_data_nxt.column_number  = col_nxt;
    out_data_nxt.mark_valid     = mark_set_nxt;
    out_data_nxt.mark_index     = gbc_pkg::POS_W'(mark_pos_nxt);
    out_data_nxt.modified       = dirty_nxt;

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    tab_w_nxt = (cfg_valid && cfg_ready) ? cfg_data : tab_w_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbc_pkg::S_IDLE;
      gs_r        <= '0;
      ge_r        <= LAST_IDX;
      row_r       <= gbc_pkg::ROW_W'(1);
      col_r       <= gbc_pkg::COL_W'(1);
      mark_set_r  <= 1'b0;
      mark_pos_r  <= '0;
      dirty_r     <= 1'b0;
      cur_byte_r  <= gbc_pkg::CH_NUL;
      tab_w_r     <= gbc_pkg::TAB_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gs_r        <= gs_nxt;
      ge_r        <= ge_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      mark_set_r  <= mark_set_nxt;
      mark_pos_r  <= mark_pos_nxt;
      dirty_r     <= dirty_nxt;
      cur_byte_r  <= cur_byte_nxt;
      tab_w_r     <= tab_w_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmd_op_r   <= cmd_op_nxt;
    cmd_byte_r <= cmd_byte_nxt;
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign in_stall  = (state_r != gbc_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

`include "gap_buffer_cursor_engine_top_assert.svh"

  `GBC_ASSERT_NOW(a_gap_order, clk, rst_n, 1'b1, gs_r <= ge_r)
  `GBC_ASSERT_NEXT(a_accept_exec, clk, rst_n, in_valid && !in_stall, state_r == gbc_pkg::S_EXEC)
  `GBC_ASSERT_NOW(a_no_term_write, clk, rst_n, ram_we, ram_waddr != LAST_IDX)
  `GBC_ASSERT_NOW(a_end_byte_zero, clk, rst_n, ge_r == LAST_IDX, cur_byte_r == gbc_pkg::CH_NUL)

endmodule

// ===== design/gbc_ram.sv =====
// generic single-write single-read ram with registered read data
module gbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== tb/sv/tb_gap_buffer_cursor_engine_top.sv =====
// self-checking testbench of the gap buffer cursor engine top level
module tb_gap_buffer_cursor_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_LEN  = gbc_pkg::BUF_SIZE_DEF;
  localparam int LAST_IDX   = gbc_pkg::BUF_SIZE_DEF - 1;
  localparam int IDLE_LIMIT = 20000;
  localparam int MAX_PRINTS = 40;
  localparam int HOLD_LEN   = 400;
  localparam logic [gbc_pkg::OPC_W-1:0] OP_UNUSED = 3'd7;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  gbc_pkg::cmd_t             in_data;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  gbc_pkg::rsp_t             out_data;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [gbc_pkg::TAB_W-1:0] cfg_data;

  gap_buffer_cursor_engine_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // shadow copy of the buffer state
  logic [gbc_pkg::BYTE_W-1:0] text_mem [0:STORE_LEN-1];
  int                         cur_lo;
  int                         cur_hi;
  logic [gbc_pkg::ROW_W-1:0]  row_cnt;
  logic [gbc_pkg::COL_W-1:0]  col_cnt;
  logic                       mark_on;
  int                         mark_at;
  logic                       dirty;
  logic [gbc_pkg::TAB_W-1:0]  tab_w;

  gbc_pkg::rsp_t expected_rsp [$];
  int   err_count    = 0;
  int   burst_left;
  int   hold_cycles  = 0;
  logic hold_req     = 1'b0;
  logic hold_ack     = 1'b0;
  int   stall_mode   = 0;
  int   pattern_left = 0;
  int   idle_cycles  = 0;

  function automatic logic [gbc_pkg::COL_W-1:0] column_step(
    input logic [gbc_pkg::BYTE_W-1:0] ch);
    return (ch == gbc_pkg::CH_TAB) ? gbc_pkg::COL_W'(tab_w) : gbc_pkg::COL_W'(1);
  endfunction

  function automatic void reset_shadow();
    for (int i = 0; i < STORE_LEN; i++) text_mem[i] = gbc_pkg::CH_NUL;
    cur_lo  = 0;
    cur_hi  = LAST_IDX;
    row_cnt = gbc_pkg::ROW_W'(1);
    col_cnt = gbc_pkg::COL_W'(1);
    mark_on = 1'b0;
    mark_at = 0;
    dirty   = 1'b0;
    tab_w   = gbc_pkg::TAB_RST;
  endfunction

  function automatic gbc_pkg::rsp_t apply_command(input logic [gbc_pkg::OPC_W-1:0] op,
                                                  input logic [gbc_pkg::BYTE_W-1:0] b);
    gbc_pkg::rsp_t              r;
    logic [gbc_pkg::STAT_W-1:0] st;
    logic [gbc_pkg::BYTE_W-1:0] ch;
    logic [gbc_pkg::COL_W-1:0]  cnt;
    int                         i;
    st = gbc_pkg::ST_OK;
    case (op)
      gbc_pkg::OP_INSERT: begin
        if (cur_lo >= cur_hi) begin
          st = gbc_pkg::ST_FULL;
        end else begin
          text_mem[cur_lo] = b;
          cur_lo++;
          if (b == gbc_pkg::CH_NL) begin
            row_cnt = row_cnt + gbc_pkg::ROW_W'(1);
            col_cnt = gbc_pkg::COL_W'(1);
          end else begin
            col_cnt = col_cnt + column_step(b);
          end
          mark_on = 1'b0;
          dirty   = 1'b1;
        end
      end
      gbc_pkg::OP_DELETE: begin
        if (cur_hi >= LAST_IDX) begin
          st = gbc_pkg::ST_AT_END;
        end else begin
          cur_hi++;
          mark_on = 1'b0;
          dirty   = 1'b1;
        end
      end
      gbc_pkg::OP_LEFT: begin
        if (cur_lo == 0) begin
          st = gbc_pkg::ST_AT_START;
        end else begin
          cur_lo--;
          cur_hi--;
          ch = text_mem[cur_lo];
          text_mem[cur_hi] = ch;
          if (ch == gbc_pkg::CH_NL) begin
            row_cnt = row_cnt - gbc_pkg::ROW_W'(1);
            // walk back to the previous newline to rebuild the column
            i   = cur_lo;
            cnt = gbc_pkg::COL_W'(1);
            while (i > 0) begin
              i--;
              if (text_mem[i] == gbc_pkg::CH_NL) break;
              cnt = cnt + column_step(text_mem[i]);
            end
            col_cnt = cnt;
          end else begin
            col_cnt = col_cnt - column_step(ch);
          end
          if (mark_on && mark_at == cur_lo) mark_at = cur_hi;
        end
      end
      gbc_pkg::OP_RIGHT: begin
        if (cur_hi >= LAST_IDX) begin
          st = gbc_pkg::ST_AT_END;
        end else begin
          ch = text_mem[cur_hi];
          if (ch == gbc_pkg::CH_NL) begin
            row_cnt = row_cnt + gbc_pkg::ROW_W'(1);
            col_cnt = gbc_pkg::COL_W'(1);
          end else begin
            col_cnt = col_cnt + column_step(ch);
          end
          text_mem[cur_lo] = ch;
          if (mark_on && mark_at == cur_hi) mark_at = cur_lo;
          cur_lo++;
          cur_hi++;
        end
      end
      gbc_pkg::OP_SET_MARK: begin
        mark_on = 1'b1;
        mark_at = cur_hi;
      end
      gbc_pkg::OP_CLEAR: begin
        cur_lo  = 0;
        cur_hi  = LAST_IDX;
        row_cnt = gbc_pkg::ROW_W'(1);
        col_cnt = gbc_pkg::COL_W'(1);
        mark_on = 1'b0;
        mark_at = 0;
        dirty   = 1'b1;
      end
      gbc_pkg::OP_CLR_MOD: dirty = 1'b0;
      default: ;
    endcase
    r.status         = st;
    r.cursor_pos     = gbc_pkg::POS_W'(cur_lo);
    r.byte_at_cursor = text_mem[cur_hi];
    r.row_number     = row_cnt;
    r.column_number  = col_cnt;
    r.mark_valid     = mark_on;
    r.mark_index     = gbc_pkg::POS_W'(mark_at);
    r.modified       = dirty;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < MAX_PRINTS)
      $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    gbc_pkg::rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("unexpected beat", 32'(out_data), 32'd0);
      end else begin
        want = expected_rsp.pop_front();
        if (out_data.status != want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.cursor_pos != want.cursor_pos)
          report_mismatch("cursor_pos", 32'(out_data.cursor_pos), 32'(want.cursor_pos));
        if (out_data.byte_at_cursor != want.byte_at_cursor)
          report_mismatch("byte_at_cursor", 32'(out_data.byte_at_cursor),
                          32'(want.byte_at_cursor));
        if (out_data.row_number != want.row_number)
          report_mismatch("row_number", 32'(out_data.row_number), 32'(want.row_number));
        if (out_data.column_number != want.column_number)
          report_mismatch("column_number", 32'(out_data.column_number),
                          32'(want.column_number));
        if (out_data.mark_valid != want.mark_valid)
          report_mismatch("mark_valid", 32'(out_data.mark_valid), 32'(want.mark_valid));
        if (out_data.mark_index != want.mark_index)
          report_mismatch("mark_index", 32'(out_data.mark_index), 32'(want.mark_index));
        if (out_data.modified != want.modified)
          report_mismatch("modified", 32'(out_data.modified), 32'(want.modified));
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_cycles <= HOLD_LEN;
      out_stall   <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      if (pattern_left == 0) begin
        stall_mode   = $urandom_range(0, 4);
        pattern_left = $urandom_range(8, 80);
      end
      pattern_left--;
      out_stall <= ($urandom_range(0, 9) < 2 * stall_mode);
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_cmd(input logic [gbc_pkg::OPC_W-1:0] op,
                          input logic [gbc_pkg::BYTE_W-1:0] b);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    in_data  <= gbc_pkg::cmd_t'({op, b});
    do @(posedge clk); while (in_stall);
    expected_rsp.push_back(apply_command(op, b));
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic drain();
    if (burst_left != 0) begin
      in_valid   <= 1'b0;
      burst_left = 0;
    end
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_tab_width(input logic [gbc_pkg::TAB_W-1:0] tw);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= tw;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tab_w = tw;
  endtask

  function automatic logic [gbc_pkg::BYTE_W-1:0] pick_byte(input int nl_pct,
                                                           input int tab_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < nl_pct) return gbc_pkg::CH_NL;
    if (roll < nl_pct + tab_pct) return gbc_pkg::CH_TAB;
    if (roll < nl_pct + tab_pct + 3)
      return ($urandom_range(0, 1) != 0) ? 8'hFF : gbc_pkg::CH_NUL;
    return gbc_pkg::BYTE_W'($urandom);
  endfunction

  task automatic test_edges_and_ops();
    send_cmd(gbc_pkg::OP_LEFT, 8'h00);
    send_cmd(gbc_pkg::OP_RIGHT, 8'hFF);
    send_cmd(gbc_pkg::OP_DELETE, 8'h55);
    send_cmd(OP_UNUSED, 8'hFF);
    send_cmd(gbc_pkg::OP_SET_MARK, 8'hAA);
    send_cmd(gbc_pkg::OP_CLR_MOD, 8'h00);
    send_cmd(gbc_pkg::OP_INSERT, gbc_pkg::CH_NUL);
    send_cmd(gbc_pkg::OP_INSERT, 8'hFF);
    send_cmd(gbc_pkg::OP_INSERT, gbc_pkg::CH_TAB);
    send_cmd(gbc_pkg::OP_INSERT, gbc_pkg::CH_NL);
    send_cmd(gbc_pkg::OP_INSERT, 8'h61);
    send_cmd(gbc_pkg::OP_INSERT, gbc_pkg::CH_TAB);
    send_cmd(gbc_pkg::OP_SET_MARK, 8'h00);
    send_cmd(gbc_pkg::OP_LEFT, 8'h00);
    send_cmd(gbc_pkg::OP_LEFT, 8'h00);
    send_cmd(gbc_pkg::OP_LEFT, 8'h00);
    send_cmd(gbc_pkg::OP_SET_MARK, 8'h00);
    send_cmd(gbc_pkg::OP_RIGHT, 8'h00);
    send_cmd(gbc_pkg::OP_LEFT, 8'h00);
    send_cmd(gbc_pkg::OP_DELETE, 8'h00);
    send_cmd(gbc_pkg::OP_CLR_MOD, 8'h00);
    send_cmd(gbc_pkg::OP_CLEAR, 8'h00);
    send_cmd(gbc_pkg::OP_CLR_MOD, 8'h00);
  endtask

  // tabs passed at one width and crossed back at another, column wraps
  task automatic test_tab_width_change();
    write_tab_width(5'd1);
    repeat (3) send_cmd(gbc_pkg::OP_INSERT, gbc_pkg::CH_TAB);
    write_tab_width(5'd16);
    repeat (3) send_cmd(gbc_pkg::OP_LEFT, 8'h00);
    repeat (3) send_cmd(gbc_pkg::OP_RIGHT, 8'h00);
    write_tab_width(5'd0);
    send_cmd(gbc_pkg::OP_INSERT, gbc_pkg::CH_TAB);
    send_cmd(gbc_pkg::OP_LEFT, 8'h00);
    write_tab_width(5'd31);
    send_cmd(gbc_pkg::OP_RIGHT, 8'h00);
    send_cmd(gbc_pkg::OP_CLEAR, 8'h00);
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    drain();
    hold_req    = !hold_req;
    burst_left  = 40;
    repeat (40) send_cmd(gbc_pkg::OP_INSERT, pick_byte(10, 10));
    repeat (10) send_cmd(gbc_pkg::OP_LEFT, 8'h00);
  endtask

  task automatic test_random_phase(input int n_items, input logic [gbc_pkg::TAB_W-1:0] tw);
    int sent;
    int roll;
    int run;
    write_tab_width(tw);
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        send_cmd(gbc_pkg::OP_INSERT, pick_byte(15, 20));
        sent++;
      end else if (roll < 50) begin
        send_cmd(gbc_pkg::OP_DELETE, gbc_pkg::BYTE_W'($urandom));
        sent++;
      end else if (roll < 68) begin
        send_cmd(gbc_pkg::OP_LEFT, gbc_pkg::BYTE_W'($urandom));
        sent++;
      end else if (roll < 82) begin
        send_cmd(gbc_pkg::OP_RIGHT, gbc_pkg::BYTE_W'($urandom));
        sent++;
      end else if (roll < 88) begin
        send_cmd(gbc_pkg::OP_SET_MARK, gbc_pkg::BYTE_W'($urandom));
        sent++;
      end else if (roll < 92) begin
        // mark set, then walked over in both directions
        run = $urandom_range(2, 20);
        send_cmd(gbc_pkg::OP_SET_MARK, 8'h00);
        repeat (run) send_cmd(gbc_pkg::OP_LEFT, 8'h00);
        repeat (run + $urandom_range(0, 4)) send_cmd(gbc_pkg::OP_RIGHT, 8'h00);
        sent += 2 * run + 1;
      end else if (roll < 96) begin
        send_cmd(gbc_pkg::OP_CLR_MOD, gbc_pkg::BYTE_W'($urandom));
        sent++;
      end else if (roll < 98) begin
        send_cmd(OP_UNUSED, gbc_pkg::BYTE_W'($urandom));
        sent++;
      end else if (roll < 99 || cur_lo < 200) begin
        send_cmd(gbc_pkg::OP_INSERT, gbc_pkg::CH_NL);
        sent++;
      end else begin
        send_cmd(gbc_pkg::OP_CLEAR, gbc_pkg::BYTE_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    burst_left   = 0;
    reset_shadow();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edges_and_ops();
    test_tab_width_change();
    test_backpressure();
    test_random_phase(125, 5'd1);
    test_random_phase(125, 5'd16);
    test_random_phase(125, 5'd8);
    test_random_phase(125, 5'd3);
    test_random_phase(125, 5'd31);
    test_random_phase(130, 5'd4);

    drain();
    repeat (20) @(posedge clk);
    if (expected_rsp.size() != 0)
      report_mismatch("leftover", 32'(expected_rsp.size()), 32'd0);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/gbc_pkg.sv
design/gbc_ram.sv
design/gap_buffer_cursor_engine_top.sv
tb/sv/tb_gap_buffer_cursor_engine_top.sv
